// ===== rtl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: types, constants and widths.
`timescale 1ns / 1ps
package ffha_pkg;
   localparam int HEAP_BYTES_DEF   = 65536;
   localparam int ALIGN_BYTES_DEF  = 8;
   localparam int HEADER_BYTES_DEF = 16;

   localparam int OFS_W  = 17;
   localparam int SIZE_W = 17;
   localparam int ADDR_W = 16;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic [1:0]        status;
   } rsp_type;
endpackage

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator: request sequencer around the header store.
//
// Usage:
//  - Request channel: drive req_data and pulse start while busy is low; the
//    transaction is taken at that edge and busy rises the next cycle.
//  - Result channel: exactly one result per request, shown on rsp_data for one
//    cycle with rsp_valid high. The receiver cannot stall it.
//  - CSR channel: csr_valid/csr_ready write heap_limit; write only while idle.
//  - Sequence: a zero-size request or an ignored free answers from the read state
//    that follows acceptance; a free of a heap address reads the header, then
//    rewrites it with the mark set. An allocation reads and then decides on each
//    header visited, takes one merge step per free neighbor merged, then grants,
//    splits, extends the break or reports full; the walk over the implicit block
//    list in the header memory sets the rate, and a new request waits for the last result.
//  - Reset: break and limit are restored; header memory contents are not
//    cleared, since the walk never reads a header below the break that was not
//    written.
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit
#(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  ffha_pkg::req_type       req_data,
   output logic                    rsp_valid,
   output ffha_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [ffha_pkg::OFS_W-1:0] csr_data
);
   import ffha_pkg::*;

   localparam int DEPTH = HEAP_BYTES / ALIGN_BYTES + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int AL_SH = $clog2(ALIGN_BYTES);
   localparam int WW    = 26; // wide enough for break + header + rounded size
   localparam int DW    = SIZE_W + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;
   localparam logic [2:0] S_HEAD  = 3'd2;
   localparam logic [2:0] S_MERGE = 3'd3;
   localparam logic [2:0] S_SPLIT = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [WW-1:0]     size_ff, size_in;     // rounded request
   logic [WW-1:0]     p_ff, p_in;           // current block start
   logic [WW-1:0]     s_ff, s_in;           // merged size of free block
   logic [WW-1:0]     n_ff, n_in;           // next header offset being read
   logic [OFS_W-1:0]  brk_ff, brk_in;
   logic [OFS_W-1:0]  limit_ff, limit_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rv_ff, rv_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [DW-1:0]     wr_data, rd_data;
   logic [WW-1:0]     rd_ofs;

   logic              h_free;
   logic [WW-1:0]     h_size, lim_w, brk_w;

   function automatic logic [AW-1:0] slot(input logic [WW-1:0] ofs);
      logic [WW-1:0] s;
      s = ofs >> AL_SH;
      if (s > WW'(DEPTH - 1)) s = WW'(DEPTH - 1);
      return s[AW-1:0];
   endfunction

   ffha_hdr_mem #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign h_free = rd_data[DW-1];
   assign h_size = WW'(rd_data[SIZE_W-1:0]);
   assign lim_w  = (WW'(limit_ff) > WW'(HEAP_BYTES)) ? WW'(HEAP_BYTES) : WW'(limit_ff);
   assign brk_w  = WW'(brk_ff);
   assign rd_addr = slot(rd_ofs);

   always_comb begin
      logic [OFS_W-1:0] h;
      state_in = state_ff;
      req_in   = req_ff;
      size_in  = size_ff;
      p_in     = p_ff;
      s_in     = s_ff;
      n_in     = n_ff;
      brk_in   = brk_ff;
      limit_in = limit_ff;
      rsp_in   = rsp_ff;
      rv_in    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = slot(p_ff);
      wr_data  = '0;
      rd_ofs   = p_ff;
      h        = OFS_W'(req_ff.block_address) - OFS_W'(HEADER_BYTES);

      if (csr_valid && state_ff == S_IDLE) begin
         limit_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            // hold off while the last result is still on the ports
            if (start && !rv_ff) begin
               req_in   = req_data;
               size_in  = ((WW'(req_data.request_size) + WW'(ALIGN_BYTES - 1)) >> AL_SH)
                          << AL_SH;
               p_in     = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            // issue read of header at p (of the freed header for a free)
            rsp_in = '{granted_address: '0, status: ST_DONE};
            if (req_ff.cmd == CMD_FREE) begin
               // free updates only the mark; read first to keep the size
               if (req_ff.block_address >= ADDR_W'(HEADER_BYTES)
                   && h[AL_SH-1:0] == '0 && h < brk_ff) begin
                  rd_ofs   = WW'(h);
                  p_in     = WW'(h);
                  state_in = S_SPLIT;
               end else begin
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (req_ff.request_size == '0) begin
               rsp_in.status = ST_ZERO;
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end else if (p_ff >= brk_w) begin
               if (brk_w + WW'(HEADER_BYTES) + size_ff > lim_w) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = slot(brk_w);
                  wr_data = {1'b0, size_ff[SIZE_W-1:0]};
                  rsp_in.granted_address = ADDR_W'(brk_w + WW'(HEADER_BYTES));
                  brk_in  = OFS_W'(brk_w + WW'(HEADER_BYTES) + size_ff);
               end
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_ofs   = p_ff;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (!h_free) begin
               p_in     = p_ff + WW'(HEADER_BYTES) + h_size;
               state_in = S_RD;
            end else begin
               s_in     = h_size;
               n_in     = p_ff + WW'(HEADER_BYTES) + h_size;
               rd_ofs   = p_ff + WW'(HEADER_BYTES) + h_size;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            // rd_data holds header at n (valid only if n < break)
            if (s_ff < size_ff && n_ff < brk_w && h_free) begin
               s_in     = s_ff + WW'(HEADER_BYTES) + h_size;
               n_in     = p_ff + WW'(HEADER_BYTES) + s_ff + WW'(HEADER_BYTES) + h_size;
               rd_ofs   = n_in;
            end else if (s_ff >= size_ff) begin
               wr_en = 1'b1;
               rsp_in.granted_address = ADDR_W'(p_ff + WW'(HEADER_BYTES));
               if (s_ff > size_ff + WW'(HEADER_BYTES)) begin
                  wr_data  = {1'b0, size_ff[SIZE_W-1:0]};
                  state_in = S_SPLIT;
               end else begin
                  wr_data  = {1'b0, s_ff[SIZE_W-1:0]};
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               // keep the merge, move on
               wr_en    = 1'b1;
               wr_data  = {1'b1, s_ff[SIZE_W-1:0]};
               p_in     = p_ff + WW'(HEADER_BYTES) + s_ff;
               state_in = S_RD;
            end
         end
         S_SPLIT: begin
            if (req_ff.cmd == CMD_FREE) begin
               state_in = S_RESP;
            end else begin
               wr_en   = 1'b1;
               wr_addr = slot(p_ff + WW'(HEADER_BYTES) + size_ff);
               wr_data = {1'b1, SIZE_W'(s_ff - size_ff - WW'(HEADER_BYTES))};
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            // free: rewrite header with the mark set
            wr_en    = 1'b1;
            wr_data  = {1'b1, rd_data[SIZE_W-1:0]};
            rv_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         brk_ff   <= '0;
         limit_ff <= OFS_W'(HEAP_BYTES_DEF);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         brk_ff   <= brk_in;
         limit_ff <= limit_in;
         rv_ff    <= rv_in;
      end
      req_ff  <= req_in;
      size_ff <= size_in;
      p_ff    <= p_in;
      s_ff    <= s_in;
      n_ff    <= n_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = (state_ff == S_IDLE);

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back results");
   a_brk_lim: assert property (@(posedge clock) disable iff (reset)
      brk_ff != $past(brk_ff) |-> brk_w <= WW'(HEAP_BYTES)) else $error("break past heap");
   a_zero_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |-> rsp_data.granted_address == '0)
      else $error("failed request granted");
endmodule

// ===== rtl/ffha_hdr_mem.sv =====
// Header store: one-write, one-read synchronous memory with registered read data.
`timescale 1ns / 1ps
module ffha_hdr_mem #(
   parameter int DEPTH = 8193,
   parameter int AW    = 14,
   parameter int DW    = 18
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== verif/tb_first_fit_heap_allocator_unit.sv =====
// Self-checking testbench for the first-fit heap allocator unit.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_unit;
   import ffha_pkg::*;

   localparam int HEAP   = HEAP_BYTES_DEF;
   localparam int ALIGN  = ALIGN_BYTES_DEF;
   localparam int HDR    = HEADER_BYTES_DEF;
   localparam int SLOTS  = HEAP / ALIGN + 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [OFS_W-1:0] csr_data = '0;

   first_fit_heap_allocator_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: header sizes and free marks, break and limit
   int unsigned hdr_size [SLOTS];
   bit          hdr_free [SLOTS];
   int unsigned brk;
   int unsigned limit_reg;
   rsp_type     grant_queue[$];
   int          errors = 0;
   int unsigned live_addr[$];

   function automatic int unsigned slot_of(int unsigned ofs);
      int unsigned s;
      s = ofs / ALIGN;
      return (s < SLOTS) ? s : SLOTS - 1;
   endfunction

   function automatic rsp_type predict_grant(req_type r);
      rsp_type     o;
      int unsigned sz, lim, p, s, n, h, a;
      o = '0;
      a = r.block_address;
      if (r.cmd == CMD_FREE) begin
         if (a >= HDR) begin
            h = a - HDR;
            if (h % ALIGN == 0 && h < brk) hdr_free[slot_of(h)] = 1'b1;
         end
         return o;
      end
      if (r.request_size == 0) begin
         o.status = ST_ZERO;
         return o;
      end
      sz  = ((r.request_size + ALIGN - 1) / ALIGN) * ALIGN;
      lim = (limit_reg < HEAP) ? limit_reg : HEAP;
      p = 0;
      while (p < brk) begin
         if (!hdr_free[slot_of(p)]) begin
            p += HDR + hdr_size[slot_of(p)];
            continue;
         end
         s = hdr_size[slot_of(p)];
         n = p + HDR + s;
         while (s < sz && n < brk && hdr_free[slot_of(n)]) begin
            s += HDR + hdr_size[slot_of(n)];
            n = p + HDR + s;
         end
         hdr_size[slot_of(p)] = s;
         if (s >= sz) begin
            hdr_free[slot_of(p)] = 1'b0;
            if (s > sz + HDR) begin
               hdr_free[slot_of(p + HDR + sz)] = 1'b1;
               hdr_size[slot_of(p + HDR + sz)] = s - sz - HDR;
               hdr_size[slot_of(p)] = sz;
            end
            o.granted_address = (p + HDR) & 16'hFFFF;
            return o;
         end
         p += HDR + s;
      end
      if (longint'(brk) + HDR + sz > longint'(lim)) begin
         o.status = ST_FULL;
         return o;
      end
      hdr_size[slot_of(brk)] = sz;
      hdr_free[slot_of(brk)] = 1'b0;
      o.granted_address = (brk + HDR) & 16'hFFFF;
      brk += HDR + sz;
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int exp_v);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (grant_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.granted_address, -1);
         end else begin
            rsp_type e;
            e = grant_queue.pop_front();
            if (rsp_data.granted_address !== e.granted_address)
               report_mismatch("granted_address", rsp_data.granted_address,
                               e.granted_address);
            if (rsp_data.status !== e.status)
               report_mismatch("status", rsp_data.status, e.status);
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_request(logic cmd, int unsigned size, int unsigned addr);
      req_type r;
      rsp_type g;
      r.cmd = cmd;
      r.request_size = size[SIZE_W-1:0];
      r.block_address = addr[ADDR_W-1:0];
      while (busy) @(posedge clock);
      start    <= 1'b1;
      req_data <= r;
      // advance until the edge that takes the transaction
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      g = predict_grant(r);
      grant_queue.push_back(g);
      if (cmd == CMD_ALLOC && g.status == ST_DONE) live_addr.push_back(g.granted_address);
      @(posedge clock);
   endtask

   task automatic drain();
      while (grant_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(int unsigned v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v[OFS_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_reg = v & 17'h1FFFF;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(CMD_ALLOC, 0, 0);            // zero-size
      send_request(CMD_FREE, 0, 0);             // free of null
      send_request(CMD_ALLOC, 1, 16'hFFFF);
      send_request(CMD_ALLOC, 24, 0);
      send_request(CMD_ALLOC, 7, 0);
      send_request(CMD_ALLOC, 65536, 0);        // oversized
      send_request(CMD_ALLOC, 131071, 0);
      send_request(CMD_FREE, 0, 8);             // below header
      send_request(CMD_FREE, 0, 21);            // misaligned
      send_request(CMD_FREE, 0, 65535);         // beyond break
      send_request(CMD_FREE, 0, 16);
      send_request(CMD_FREE, 0, 16);            // double free
      send_request(CMD_FREE, 0, 40);
      send_request(CMD_FREE, 0, 48);            // inside a block
      send_request(CMD_ALLOC, 40, 0);           // merge adjacent free blocks
      send_request(CMD_ALLOC, 8, 0);            // no free block fits: extends the break
      drain();
   endtask

   task automatic test_limits();
      write_limit(0);
      send_request(CMD_ALLOC, 8, 0);
      write_limit(131071);
      send_request(CMD_ALLOC, 60000, 0);
      send_request(CMD_ALLOC, 8000, 0);
      write_limit(HEAP);
      drain();
   endtask

   task automatic test_random(int count);
      int unsigned k, a;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         if (k < 45) begin
            send_request(CMD_ALLOC, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 131071)
                                                                 : $urandom_range(1, 300), 0);
         end else if (k < 85 && live_addr.size() != 0) begin
            a = $urandom_range(0, live_addr.size() - 1);
            send_request(CMD_FREE, $urandom, live_addr[a]);
            live_addr.delete(a);
         end else begin
            send_request($urandom_range(0, 1), $urandom, $urandom);
         end
         if (i % 250 == 100) drain();         // hold until every result is in
         if ($urandom_range(0, 1) == 0) idle_gap();
      end
      drain();
   endtask

   initial begin
      brk = 0;
      limit_reg = 65536;
      foreach (hdr_free[i]) begin
         hdr_free[i] = 1'b0;
         hdr_size[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      test_random(400);
      write_limit(4096);
      test_random(300);
      write_limit(1000);
      test_random(100);
      write_limit(HEAP);
      test_random(200);
      drain();
      if (errors == 0) $display("tb_first_fit_heap_allocator_unit: PASS");
      else $display("tb_first_fit_heap_allocator_unit: FAIL");
      $finish;
   end

   initial begin
      #200ms;
      $display("tb_first_fit_heap_allocator_unit: FAIL");
      $finish;
   end
endmodule
